// ===== rtl/kdepq_pkg.sv =====
// ============================================================================
// kdepq_pkg
// shared types and codes for the keyed double-ended priority queue
// ============================================================================
`default_nettype none

package kdepq_pkg;

    // fixed widths of the transaction fields
    localparam int ID_FIELD_W    = 16;
    localparam int LEVEL_FIELD_W = 8;

    // defaults for the top level parameters
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_ID_BITS    = 16;
    localparam int DEF_LEVEL_BITS = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_MAX    = 2'd2;
    localparam logic [1:0] OP_MIN    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [ID_FIELD_W-1:0]    item_id;
        logic [LEVEL_FIELD_W-1:0] item_level;
    } req_t;

    typedef struct packed {
        logic [ID_FIELD_W-1:0] result_id;
        logic [1:0]            status;
    } rsp_t;

    // command broadcast to every cell of the sorted chain
    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_INSERT,
        CMD_REMOVE
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/kdepq_cell.sv =====
// ============================================================================
// kdepq_cell
// one slot of the sorted chain, ascending in (level, id)
// ============================================================================
`default_nettype none

module kdepq_cell #(
    parameter int ID_BITS    = kdepq_pkg::DEF_ID_BITS,
    parameter int LEVEL_BITS = kdepq_pkg::DEF_LEVEL_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire kdepq_pkg::cell_cmd_t  cmd,
    input  wire logic [LEVEL_BITS-1:0] key_level,
    input  wire logic [ID_BITS-1:0]    key_id,
    input  wire logic                  left_valid,
    input  wire logic [ID_BITS-1:0]    left_id,
    input  wire logic [LEVEL_BITS-1:0] left_level,
    input  wire logic                  left_gt,
    input  wire logic                  right_valid,
    input  wire logic [ID_BITS-1:0]    right_id,
    input  wire logic [LEVEL_BITS-1:0] right_level,
    output logic                       valid,
    output logic [ID_BITS-1:0]         id,
    output logic [LEVEL_BITS-1:0]      level,
    output logic                       gt
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [ID_BITS-1:0]    id_reg;
    logic [ID_BITS-1:0]    id_next;
    logic [LEVEL_BITS-1:0] level_reg;
    logic [LEVEL_BITS-1:0] level_next;
    logic                  above_key;
    logic                  at_or_above_key;

    assign above_key       = {level_reg, id_reg} >  {key_level, key_id};
    assign at_or_above_key = {level_reg, id_reg} >= {key_level, key_id};

    // an empty slot counts as larger than any key
    assign gt = !valid_reg || above_key;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        level_next = level_reg;
        case (cmd)
            kdepq_pkg::CMD_INSERT:
            begin
                if (gt)
                begin
                    if (left_gt)
                    begin
                        valid_next = left_valid;
                        id_next    = left_id;
                        level_next = left_level;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        id_next    = key_id;
                        level_next = key_level;
                    end
                end
            end
            kdepq_pkg::CMD_REMOVE:
            begin
                // everything from the removed entry upwards shifts down one place
                if (valid_reg && at_or_above_key)
                begin
                    valid_next = right_valid;
                    id_next    = right_id;
                    level_next = right_level;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        level_reg <= level_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign level = level_reg;

endmodule

`default_nettype wire

// ===== rtl/kdepq_tree.sv =====
// ============================================================================
// kdepq_tree
// registered binary select tree: returns the lowest flagged leaf
// ============================================================================
`default_nettype none

module kdepq_tree #(
    parameter int LEAVES = kdepq_pkg::DEF_CAPACITY,
    parameter int WIDTH  = kdepq_pkg::DEF_ID_BITS + kdepq_pkg::DEF_LEVEL_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             leaf_flag [LEAVES],
    input  wire logic [WIDTH-1:0] leaf_data [LEAVES],
    output logic                  root_flag,
    output logic [WIDTH-1:0]      root_data
);

    localparam int DEPTH = $clog2(LEAVES);
    localparam int SPAN  = 1 << DEPTH;

    logic             lf [SPAN];
    logic [WIDTH-1:0] ld [SPAN];
    logic             nf_reg [1:SPAN-1];
    logic [WIDTH-1:0] nd_reg [1:SPAN-1];

    genvar j;
    genvar k;

    generate
        for (j = 0; j < SPAN; j++)
        begin : g_leaf
            if (j < LEAVES)
            begin : g_real
                assign lf[j] = leaf_flag[j];
                assign ld[j] = leaf_data[j];
            end
            else
            begin : g_pad
                assign lf[j] = 1'b0;
                assign ld[j] = '0;
            end
        end

        // heap numbering: node k has children 2k and 2k+1
        for (k = 1; k < SPAN; k++)
        begin : g_node
            logic             af;
            logic             bf;
            logic [WIDTH-1:0] ad;
            logic [WIDTH-1:0] bd;

            if (2 * k >= SPAN)
            begin : g_from_leaf
                assign af = lf[2*k-SPAN];
                assign ad = ld[2*k-SPAN];
                assign bf = lf[2*k+1-SPAN];
                assign bd = ld[2*k+1-SPAN];
            end
            else
            begin : g_from_node
                assign af = nf_reg[2*k];
                assign ad = nd_reg[2*k];
                assign bf = nf_reg[2*k+1];
                assign bd = nd_reg[2*k+1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    nf_reg[k] <= 1'b0;
                end
                else
                begin
                    nf_reg[k] <= af || bf;
                end
            end

            always_ff @(posedge clk)
            begin
                nd_reg[k] <= af ? ad : bd;
            end
        end
    endgenerate

    assign root_flag = nf_reg[1];
    assign root_data = nd_reg[1];

endmodule

`default_nettype wire

// ===== rtl/keyed_double_ended_priority_queue.sv =====
// ============================================================================
// keyed_double_ended_priority_queue
// id/level table kept sorted in a chain of cells, with keyed add and remove
// ============================================================================
// usage: a request transaction (req) carries an opcode, an id and a level;
// every request gives exactly one response transaction (rsp) with a result
// id and a status. add inserts an id or moves it to a new level, remove
// deletes by id, max/min return the id of the highest/lowest (level, id).
// the cells hold the entries in ascending order; a broadcast insert or
// remove shifts them one place. finding an id, or the chain's first or
// last entry, goes through a registered select tree of log2(CAPACITY)
// levels. a remove or a new add then takes one chain step, and an add
// that moves an existing id a remove step and then an insert step. one
// request is in work at a time and the next is taken the cycle after the
// response is written. req_stall is high while a request is in work.
// the response sits in an output register; a stalled response holds and
// the next request is still taken, its response waiting for the register.
// reset empties the table at once (only the cell valid bits clear).
// ============================================================================
`default_nettype none

module keyed_double_ended_priority_queue #(
    parameter int CAPACITY   = kdepq_pkg::DEF_CAPACITY,
    parameter int ID_BITS    = kdepq_pkg::DEF_ID_BITS,
    parameter int LEVEL_BITS = kdepq_pkg::DEF_LEVEL_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire kdepq_pkg::req_t  req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output kdepq_pkg::rsp_t       rsp
);

    localparam int KW    = ID_BITS + LEVEL_BITS;
    localparam int DEPTH = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int WW    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_STEP,
        S_FINISH
    } state_t;

    state_t                          state_reg;
    logic [WW-1:0]                   wait_reg;
    kdepq_pkg::cell_cmd_t            cmd_reg;
    logic [CW-1:0]                   count_reg;
    logic [1:0]                      op_reg;
    logic [ID_BITS-1:0]              key_id_reg;
    logic [LEVEL_BITS-1:0]           key_level_reg;
    logic [LEVEL_BITS-1:0]           new_level_reg;
    logic [1:0]                      status_reg;
    logic [kdepq_pkg::ID_FIELD_W-1:0] rid_reg;
    logic                            out_valid_reg;
    kdepq_pkg::rsp_t                 out_reg;

    logic [CAPACITY-1:0]   cell_valid;
    logic [ID_BITS-1:0]    cell_id    [CAPACITY];
    logic [LEVEL_BITS-1:0] cell_level [CAPACITY];
    logic                  cell_gt    [CAPACITY];

    logic                  leaf_flag [CAPACITY];
    logic [KW-1:0]         leaf_data [CAPACITY];
    logic                  hit;
    logic [KW-1:0]         hit_data;
    logic [ID_BITS-1:0]    hit_id;
    logic [LEVEL_BITS-1:0] hit_level;

    genvar i;

    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                  lv;
            logic [ID_BITS-1:0]    lid;
            logic [LEVEL_BITS-1:0] llv;
            logic                  lgt;
            logic                  rv;
            logic [ID_BITS-1:0]    rid;
            logic [LEVEL_BITS-1:0] rlv;

            if (i == 0)
            begin : g_first
                assign lv  = 1'b0;
                assign lid = '0;
                assign llv = '0;
                assign lgt = 1'b0;
            end
            else
            begin : g_inner_left
                assign lv  = cell_valid[i-1];
                assign lid = cell_id[i-1];
                assign llv = cell_level[i-1];
                assign lgt = cell_gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign rv  = 1'b0;
                assign rid = '0;
                assign rlv = '0;
            end
            else
            begin : g_inner_right
                assign rv  = cell_valid[i+1];
                assign rid = cell_id[i+1];
                assign rlv = cell_level[i+1];
            end

            kdepq_cell #(
                .ID_BITS    (ID_BITS),
                .LEVEL_BITS (LEVEL_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd_reg),
                .key_level   (key_level_reg),
                .key_id      (key_id_reg),
                .left_valid  (lv),
                .left_id     (lid),
                .left_level  (llv),
                .left_gt     (lgt),
                .right_valid (rv),
                .right_id    (rid),
                .right_level (rlv),
                .valid       (cell_valid[i]),
                .id          (cell_id[i]),
                .level       (cell_level[i]),
                .gt          (cell_gt[i])
            );

            // leaf select: id match, last occupied cell, or first cell
            always_comb
            begin
                case (op_reg)
                    kdepq_pkg::OP_MAX: leaf_flag[i] = cell_valid[i] && !rv;
                    kdepq_pkg::OP_MIN: leaf_flag[i] = cell_valid[i] && (i == 0);
                    default:           leaf_flag[i] = cell_valid[i] &&
                                                      (cell_id[i] == key_id_reg);
                endcase
            end

            assign leaf_data[i] = {cell_level[i], cell_id[i]};
        end
    endgenerate

    kdepq_tree #(
        .LEAVES (CAPACITY),
        .WIDTH  (KW)
    ) u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .leaf_flag (leaf_flag),
        .leaf_data (leaf_data),
        .root_flag (hit),
        .root_data (hit_data)
    );

    assign hit_id    = hit_data[ID_BITS-1:0];
    assign hit_level = hit_data[KW-1:ID_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            cmd_reg       <= kdepq_pkg::CMD_NOP;
            count_reg     <= '0;
            op_reg        <= kdepq_pkg::OP_ADD;
            key_id_reg    <= '0;
            key_level_reg <= '0;
            new_level_reg <= '0;
            status_reg    <= kdepq_pkg::ST_OK;
            rid_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // in finish the output register is reloaded or held there
            if (out_valid_reg && !rsp_stall && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg        <= req.opcode;
                        key_id_reg    <= ID_BITS'(req.item_id);
                        new_level_reg <= LEVEL_BITS'(req.item_level);
                        wait_reg      <= WW'(DEPTH);
                        state_reg     <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_reg <= wait_reg - WW'(1);
                    end
                    else
                    begin
                        rid_reg    <= '0;
                        status_reg <= kdepq_pkg::ST_OK;
                        cmd_reg    <= kdepq_pkg::CMD_NOP;
                        state_reg  <= S_FINISH;
                        case (op_reg)
                            kdepq_pkg::OP_ADD:
                            begin
                                if (hit)
                                begin
                                    // move: take the old entry out, then insert
                                    cmd_reg       <= kdepq_pkg::CMD_REMOVE;
                                    key_level_reg <= hit_level;
                                    state_reg     <= S_STEP;
                                end
                                else if (count_reg == CW'(CAPACITY))
                                begin
                                    status_reg <= kdepq_pkg::ST_FULL;
                                end
                                else
                                begin
                                    cmd_reg       <= kdepq_pkg::CMD_INSERT;
                                    key_level_reg <= new_level_reg;
                                    state_reg     <= S_STEP;
                                end
                            end
                            kdepq_pkg::OP_REMOVE:
                            begin
                                if (hit)
                                begin
                                    cmd_reg       <= kdepq_pkg::CMD_REMOVE;
                                    key_level_reg <= hit_level;
                                    state_reg     <= S_STEP;
                                end
                                else
                                begin
                                    status_reg <= kdepq_pkg::ST_ABSENT;
                                end
                            end
                            default:
                            begin
                                if (hit)
                                begin
                                    rid_reg <= kdepq_pkg::ID_FIELD_W'(hit_id);
                                end
                                else
                                begin
                                    status_reg <= kdepq_pkg::ST_EMPTY;
                                end
                            end
                        endcase
                    end
                end
                S_STEP:
                begin
                    if (cmd_reg == kdepq_pkg::CMD_INSERT)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    else if (cmd_reg == kdepq_pkg::CMD_REMOVE)
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                    if (cmd_reg == kdepq_pkg::CMD_REMOVE && op_reg == kdepq_pkg::OP_ADD)
                    begin
                        cmd_reg       <= kdepq_pkg::CMD_INSERT;
                        key_level_reg <= new_level_reg;
                    end
                    else
                    begin
                        cmd_reg   <= kdepq_pkg::CMD_NOP;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || !rsp_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= {rid_reg, status_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // occupied cells and the entry count agree
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == count_reg)
        else $error("cell occupancy differs from entry count");

    // an insert never reaches a full chain
    a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP && cmd_reg == kdepq_pkg::CMD_INSERT)
        |-> count_reg < CW'(CAPACITY))
        else $error("insert into a full chain");

    // the two lowest cells stay in ascending order
    a_chain_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> (cell_valid[0] &&
            {cell_level[0], cell_id[0]} < {cell_level[1], cell_id[1]}))
        else $error("chain out of order");

    // an empty response carries no id
    a_empty_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == kdepq_pkg::ST_EMPTY) |-> rsp.result_id == '0)
        else $error("empty response with an id");

endmodule

`default_nettype wire
